// File: rtl/hdms_pkg.sv
// Package for the hold duration mode selector: modes, register indexes, widths and helpers.
`default_nettype none

package hdms_pkg;

   // widths of the fields and registers
   localparam int MS_W    = 16;
   localparam int POS_W   = 10;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 3;

   // blink timing in milliseconds
   localparam int PERIOD_MS    = 1000;
   localparam int BLINK_ON_MS  = 150;
   localparam int BLINK_OFF_MS = 100;
   localparam int BLINK_STEP_MS = BLINK_ON_MS + BLINK_OFF_MS;
   localparam int MAX_BLINKS   = 4;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(PERIOD_MS - 1);

   // register reset values
   localparam logic [MS_W-1:0] MAX_WAIT_RESET      = MS_W'(12000);
   localparam logic [MS_W-1:0] DEMO_START_RESET    = MS_W'(2000);
   localparam logic [MS_W-1:0] SET_ID_START_RESET  = MS_W'(5000);
   localparam logic [MS_W-1:0] FACTORY_START_RESET = MS_W'(8000);
   localparam logic [MS_W-1:0] FACTORY_END_RESET   = MS_W'(11000);

   typedef enum logic [MODE_W-1:0] {
      MODE_RUN     = 2'd0,
      MODE_DEMO    = 2'd1,
      MODE_SET_ID  = 2'd2,
      MODE_FACTORY = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_WAIT      = 3'd0,
      CSR_DEMO_START    = 3'd1,
      CSR_SET_ID_START  = 3'd2,
      CSR_FACTORY_START = 3'd3,
      CSR_FACTORY_END   = 3'd4
   } csr_index_type;

   // thresholds as one group
   typedef struct packed {
      logic [MS_W-1:0] max_wait;
      logic [MS_W-1:0] demo_start;
      logic [MS_W-1:0] set_id_start;
      logic [MS_W-1:0] factory_start;
      logic [MS_W-1:0] factory_end;
   } thresholds_type;

   // classify a hold time; thresholds compared literally, in priority order
   function automatic mode_type mode_of(input logic [MS_W-1:0] h, input thresholds_type t);
      mode_type m;
      if (h >= t.factory_start && h < t.factory_end) begin
         m = MODE_FACTORY;
      end else if (h >= t.set_id_start && h < t.factory_start) begin
         m = MODE_SET_ID;
      end else if (h >= t.demo_start && h < t.set_id_start) begin
         m = MODE_DEMO;
      end else begin
         m = MODE_RUN;
      end
      return m;
   endfunction

   // LED drive from hold time and position inside the blink period
   function automatic logic led_of(input logic [MS_W-1:0] h, input logic [POS_W-1:0] pos,
                                   input thresholds_type t);
      logic [2:0] n;
      logic       lit;
      n   = 3'd0;
      lit = 1'b0;
      if (h >= t.factory_start) begin
         n = 3'd4;
      end else if (h >= t.set_id_start) begin
         n = 3'd2;
      end else if (h >= t.demo_start) begin
         n = 3'd1;
      end
      for (int i = 0; i < MAX_BLINKS; i++) begin
         if (3'(i) < n && pos >= POS_W'(i * BLINK_STEP_MS)
             && pos < POS_W'(i * BLINK_STEP_MS + BLINK_ON_MS)) begin
            lit = 1'b1;
         end
      end
      return lit;
   endfunction

endpackage

`default_nettype wire

// File: rtl/hdms_req_if.sv
// Request channel of the hold duration mode selector: one beat per millisecond tick.
`default_nettype none

interface hdms_req_if;
   logic valid;
   logic ready;
   logic start_check;
   logic switch_pressed;

   modport source (output valid, output start_check, output switch_pressed, input ready);
   modport sink   (input valid, input start_check, input switch_pressed, output ready);
endinterface

`default_nettype wire

// File: rtl/hdms_rsp_if.sv
// Response channel of the hold duration mode selector: LED drive and mode report.
`default_nettype none

interface hdms_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_on;
   logic       selection_done;
   logic [1:0] final_mode;
   logic [1:0] pending_mode;

   modport source (output valid, output led_on, output selection_done, output final_mode,
                   output pending_mode, input ready);
   modport sink   (input valid, input led_on, input selection_done, input final_mode,
                   input pending_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/hold_duration_mode_selector_unit.sv
// Top level of the hold duration mode selector: input stage, tick logic, response register.
//
// Usage: send one request beat per millisecond tick on req_chan, carrying
// start_check and switch_pressed. Every request beat yields exactly one
// response beat on rsp_chan with led_on, selection_done, final_mode and
// pending_mode. The thresholds sit in five 16-bit registers written through
// csr_we / csr_index / csr_wdata; write them only while no beat is in flight.
// From request acceptance to response valid, the beat sits in the input
// register while the tick logic runs against the hold state, and then the
// response register loads it once that register is free, so the response
// beat leaves from the response register. Throughput is one beat per cycle
// while the receiver does not stall, set by the single update of the hold counters per beat.
// Reset (synchronous, active high) clears both stages, stops any running
// measurement and loads the default thresholds (12000, 2000, 5000, 8000,
// 11000 ms). When the receiver stalls, the response register holds its beat,
// the input register fills, and then req_chan.ready drops; nothing is lost.
`default_nettype none

module hold_duration_mode_selector_unit
   import hdms_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   hdms_req_if.sink                  req_chan,
   hdms_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MS_W-1:0]      csr_wdata
);

   // configuration registers
   thresholds_type thr_ff;

   // input stage
   logic in_valid_ff;
   logic in_start_ff;
   logic in_pressed_ff;

   // hold state
   logic             measuring_ff, measuring_in;
   logic [MS_W-1:0]  elapsed_ff, elapsed_in;
   logic [MS_W-1:0]  held_ff, held_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   // response stage
   logic     rsp_valid_ff;
   logic     led_ff, led_in;
   logic     done_ff, done_in;
   mode_type final_ff, final_in;
   mode_type pending_ff, pending_in;

   logic rsp_free;
   logic in_move;
   logic req_take;

   logic [MS_W-1:0]  cur_elapsed;
   logic [MS_W-1:0]  cur_held;
   logic [POS_W-1:0] cur_pos;

   // handshake: response register frees when empty or taken
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign in_move  = in_valid_ff && rsp_free;
   assign req_chan.ready = !in_valid_ff || in_move;
   assign req_take = req_chan.valid && req_chan.ready;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.max_wait      <= MAX_WAIT_RESET;
         thr_ff.demo_start    <= DEMO_START_RESET;
         thr_ff.set_id_start  <= SET_ID_START_RESET;
         thr_ff.factory_start <= FACTORY_START_RESET;
         thr_ff.factory_end   <= FACTORY_END_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_WAIT:      thr_ff.max_wait      <= csr_wdata;
            CSR_DEMO_START:    thr_ff.demo_start    <= csr_wdata;
            CSR_SET_ID_START:  thr_ff.set_id_start  <= csr_wdata;
            CSR_FACTORY_START: thr_ff.factory_start <= csr_wdata;
            CSR_FACTORY_END:   thr_ff.factory_end   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold the request beat in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_start_ff   <= req_chan.start_check;
         in_pressed_ff <= req_chan.switch_pressed;
      end
   end

   // tick logic: a fresh start times from zero
   assign cur_elapsed = measuring_ff ? elapsed_ff : '0;
   assign cur_held    = measuring_ff ? held_ff : '0;
   assign cur_pos     = measuring_ff ? pos_ff : '0;

   always_comb begin
      measuring_in = measuring_ff;
      elapsed_in   = elapsed_ff;
      held_in      = held_ff;
      pos_in       = pos_ff;
      led_in       = 1'b0;
      done_in      = 1'b0;
      final_in     = MODE_RUN;
      pending_in   = MODE_RUN;
      if (!measuring_ff && !in_start_ff) begin
         // idle tick: report nothing
      end else if (!measuring_ff && !in_pressed_ff) begin
         // start with switch released: run at once
         done_in = 1'b1;
      end else if (in_pressed_ff && cur_elapsed < thr_ff.max_wait) begin
         // still held: record, report pending, advance counters
         measuring_in = 1'b1;
         held_in      = cur_elapsed;
         led_in       = led_of(cur_elapsed, cur_pos, thr_ff);
         pending_in   = mode_of(cur_elapsed, thr_ff);
         elapsed_in   = cur_elapsed + MS_W'(1);
         pos_in       = (cur_pos == POS_LAST) ? '0 : cur_pos + POS_W'(1);
      end else begin
         // released or timed out: report final mode
         measuring_in = 1'b0;
         done_in      = 1'b1;
         final_in     = mode_of(cur_held, thr_ff);
      end
   end

   // advance hold state once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         measuring_ff <= 1'b0;
         elapsed_ff   <= '0;
         held_ff      <= '0;
         pos_ff       <= '0;
      end else if (in_move) begin
         measuring_ff <= measuring_in;
         elapsed_ff   <= elapsed_in;
         held_ff      <= held_in;
         pos_ff       <= pos_in;
      end
   end

   // load the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         led_ff     <= led_in;
         done_ff    <= done_in;
         final_ff   <= final_in;
         pending_ff <= pending_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.led_on         = led_ff;
   assign rsp_chan.selection_done = done_ff;
   assign rsp_chan.final_mode     = final_ff;
   assign rsp_chan.pending_mode   = pending_ff;

   // a done beat never lights the LED nor reports a pending mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !led_ff && pending_ff == MODE_RUN)
      else $error("done beat carries LED or pending mode");

   // a measurement ends only together with a done beat
   assert property (@(posedge clock) disable iff (reset)
      in_move && measuring_ff && !measuring_in |=> rsp_valid_ff && done_ff)
      else $error("measurement ended without a done beat");

   // period position stays inside one period
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("period position out of range");

   // while measuring the recorded hold trails the elapsed count by one
   assert property (@(posedge clock) disable iff (reset)
      measuring_ff |-> elapsed_ff == held_ff + MS_W'(1))
      else $error("hold time and elapsed count out of step");

endmodule

`default_nettype wire
